/* rtl/core/atd_pkg.sv */
// Package for the adaptive touch detector: register indexes, reset values
// and fixed widths. No dependencies.
`default_nettype none
package atd_pkg;

  localparam int unsigned MEAS_W_DEF = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_W      = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_DIV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MULT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOGUS_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASSUMED_MEAS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ASSUMED_NOISE = 3'd6;

  // register reset values
  localparam logic [7:0]  MARGIN_DIV_RST    = 8'd8;
  localparam logic [3:0]  NOISE_MULT_RST    = 4'd4;
  localparam logic [3:0]  BASE_SHIFT_RST    = 4'd4;
  localparam logic [3:0]  NOISE_SHIFT_RST   = 4'd4;
  localparam logic [15:0] BOGUS_LIMIT_RST   = 16'd65535;
  localparam logic [15:0] ASSUMED_MEAS_RST  = 16'd1000;
  localparam logic [15:0] ASSUMED_NOISE_RST = 16'd10;

endpackage
`default_nettype wire

/* rtl/core/adaptive_touch_detector.sv */
// Adaptive capacitive touch detector with baseline and noise tracking.
// Depends on atd_pkg.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  in      | sink      | in_valid_i/in_ready_o, measurement_i, latch_was_read_i
//  out     | source    | out_valid_o/out_ready_i, accepted_o .. noise_level_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// A valid word passes the noise, divide, margin, decide, base and output states:
// the margin quotient comes from a restoring divider, one quotient bit a cycle.
// A bogus word goes from idle straight to output. One word is worked on at a
// time; in_ready_o is high in idle, and the next word is taken while the
// result register still waits on out_ready_i. Reset loads the register
// defaults and the estimates that follow from them.
`default_nettype none
module adaptive_touch_detector import atd_pkg::*; #(
  parameter int unsigned MEASURE_WIDTH = MEAS_W_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [MEASURE_WIDTH-1:0] measurement_i,
  input  wire logic                     latch_was_read_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          accepted_o,
  output logic                          touching_o,
  output logic                          touched_event_o,
  output logic                          released_event_o,
  output logic                          touch_latch_o,
  output logic [OUT_W-1:0]              baseline_o,
  output logic [OUT_W-1:0]              noise_level_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned W     = MEASURE_WIDTH;
  localparam int unsigned MW    = W + 6;
  localparam int unsigned CMP_W = (W > 16) ? W : 16;
  localparam int unsigned CNT_W = $clog2(W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NOISE  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MARGIN = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_BASE   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [W-1:0]     BVAL_RST = W'(ASSUMED_MEAS_RST);
  localparam logic [W-1:0]     NVAL_RST = W'(ASSUMED_NOISE_RST);
  localparam logic [ACC_W-1:0] BACC_RST = ACC_W'(BVAL_RST) << BASE_SHIFT_RST;
  localparam logic [ACC_W-1:0] NACC_RST = ACC_W'(NVAL_RST) << NOISE_SHIFT_RST;

  logic [2:0] state_q, state_d;

  // config registers
  logic [7:0]  div_q, div_d;
  logic [3:0]  nmul_q, nmul_d;
  logic [3:0]  bsh_q, bsh_d;
  logic [3:0]  nsh_q, nsh_d;
  logic [15:0] lim_q, lim_d;
  logic [15:0] am_q, am_d;
  logic [15:0] an_q, an_d;
  logic        reload;

  // tracking state
  logic [W-1:0]     bval_q, prev_q, nval_q;
  logic [ACC_W-1:0] bacc_q, nacc_q;
  logic             touch_q, latch_q, pend_q;

  // per-word working registers
  logic [W-1:0]     m_q, dq_q;
  logic [7:0]       rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W+4:0]     margin_q;
  logic             ok_q, now_q, rise_q, fall_q;

  // result register
  logic             out_valid_q;
  logic             o_acc_q, o_touch_q, o_rise_q, o_fall_q, o_latch_q;
  logic [OUT_W-1:0] o_base_q, o_noise_q;

  logic in_fire, cfg_fire, out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // config decode
  always_comb begin
    div_d  = div_q;
    nmul_d = nmul_q;
    bsh_d  = bsh_q;
    nsh_d  = nsh_q;
    lim_d  = lim_q;
    am_d   = am_q;
    an_d   = an_q;
    reload = 1'b0;
    if (cfg_fire) begin
      reload = 1'b1;
      case (cfg_index_i)
        REG_MARGIN_DIV:    div_d  = cfg_data_i[7:0];
        REG_NOISE_MULT:    nmul_d = cfg_data_i[3:0];
        REG_BASE_SHIFT:    bsh_d  = cfg_data_i[3:0];
        REG_NOISE_SHIFT:   nsh_d  = cfg_data_i[3:0];
        REG_BOGUS_LIMIT:   lim_d  = cfg_data_i;
        REG_ASSUMED_MEAS:  am_d   = cfg_data_i;
        REG_ASSUMED_NOISE: an_d   = cfg_data_i;
        default:           reload = 1'b0;
      endcase
    end
  end

  // datapath terms
  logic [W-1:0]     diff;
  logic [ACC_W-1:0] nacc_new, bacc_new;
  logic [8:0]       trial;
  logic             q_bit;
  logic [W+3:0]     prod;
  logic             up, down, bogus;

  always_comb begin
    bogus    = !(CMP_W'(measurement_i) < CMP_W'(lim_q));
    diff     = (m_q > prev_q) ? (m_q - prev_q) : (prev_q - m_q);
    nacc_new = nacc_q - ACC_W'(nval_q) + ACC_W'(diff);
    trial    = {rem_q, dq_q[W-1]};
    q_bit    = (trial >= {1'b0, div_q});  // divisor zero gives all ones
    prod     = (W+4)'(nmul_q) * (W+4)'(nval_q);
    up       = MW'(m_q) > (MW'(bval_q) + MW'(margin_q));
    down     = MW'(bval_q) > (MW'(m_q) + MW'(margin_q));
    bacc_new = bacc_q - ACC_W'(bval_q) + ACC_W'(m_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = bogus ? S_OUT : S_NOISE;
      S_NOISE:  state_d = S_DIV;
      S_DIV:    if (cnt_q == '0) state_d = S_MARGIN;
      S_MARGIN: state_d = S_DECIDE;
      S_DECIDE: state_d = S_BASE;
      S_BASE:   state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_q       <= MARGIN_DIV_RST;
      nmul_q      <= NOISE_MULT_RST;
      bsh_q       <= BASE_SHIFT_RST;
      nsh_q       <= NOISE_SHIFT_RST;
      lim_q       <= BOGUS_LIMIT_RST;
      am_q        <= ASSUMED_MEAS_RST;
      an_q        <= ASSUMED_NOISE_RST;
      bval_q      <= BVAL_RST;
      prev_q      <= BVAL_RST;
      nval_q      <= NVAL_RST;
      bacc_q      <= BACC_RST;
      nacc_q      <= NACC_RST;
      touch_q     <= 1'b0;
      latch_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      m_q         <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      margin_q    <= '0;
      ok_q        <= 1'b0;
      now_q       <= 1'b0;
      rise_q      <= 1'b0;
      fall_q      <= 1'b0;
      o_acc_q     <= 1'b0;
      o_touch_q   <= 1'b0;
      o_rise_q    <= 1'b0;
      o_fall_q    <= 1'b0;
      o_latch_q   <= 1'b0;
      o_base_q    <= '0;
      o_noise_q   <= '0;
    end else begin
      state_q <= state_d;
      div_q   <= div_d;
      nmul_q  <= nmul_d;
      bsh_q   <= bsh_d;
      nsh_q   <= nsh_d;
      lim_q   <= lim_d;
      am_q    <= am_d;
      an_q    <= an_d;

      if (reload) begin
        // reload estimates with the freshly written registers
        bval_q <= W'(am_d);
        prev_q <= W'(am_d);
        nval_q <= W'(an_d);
        bacc_q <= ACC_W'(W'(am_d)) << bsh_d;
        nacc_q <= ACC_W'(W'(an_d)) << nsh_d;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            m_q    <= measurement_i;
            dq_q   <= measurement_i;
            rem_q  <= '0;
            cnt_q  <= CNT_W'(W - 1);
            ok_q   <= !bogus;
            rise_q <= 1'b0;
            fall_q <= 1'b0;
            pend_q <= pend_q | latch_was_read_i;
          end
        end
        S_NOISE: begin
          nacc_q <= nacc_new;
          nval_q <= W'(nacc_new >> nsh_q);
          prev_q <= m_q;
        end
        S_DIV: begin
          rem_q <= q_bit ? trial[7:0] - div_q : trial[7:0];
          dq_q  <= {dq_q[W-2:0], q_bit};
          cnt_q <= cnt_q - CNT_W'(1);
        end
        S_MARGIN: begin
          margin_q <= (W+5)'(dq_q) + (W+5)'(prod);
        end
        S_DECIDE: begin
          now_q <= up ? 1'b1 : (down ? 1'b0 : touch_q);
        end
        S_BASE: begin
          if (now_q == touch_q) begin
            bacc_q <= bacc_new;
            bval_q <= W'(bacc_new >> bsh_q);
          end else begin
            // touch state changed: baseline snaps to the measurement
            bacc_q <= ACC_W'(m_q) << bsh_q;
            bval_q <= m_q;
          end
          rise_q  <= now_q && !touch_q;
          fall_q  <= !now_q && touch_q;
          if (now_q && !touch_q) begin
            latch_q <= 1'b1;
          end else if (latch_q && pend_q) begin
            latch_q <= 1'b0;
          end
          pend_q  <= 1'b0;
          touch_q <= now_q;
        end
        S_OUT: begin
          if (out_load) begin
            o_acc_q   <= ok_q;
            o_touch_q <= touch_q;
            o_rise_q  <= rise_q;
            o_fall_q  <= fall_q;
            o_latch_q <= latch_q;
            o_base_q  <= OUT_W'(bval_q);
            o_noise_q <= OUT_W'(nval_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = o_acc_q;
  assign touching_o       = o_touch_q;
  assign touched_event_o  = o_rise_q;
  assign released_event_o = o_fall_q;
  assign touch_latch_o    = o_latch_q;
  assign baseline_o       = o_base_q;
  assign noise_level_o    = o_noise_q;

endmodule
`default_nettype wire
